>>> design/sorted_lock_set_defines.svh
// ----------------------------------------------------------------------------
// sorted_lock_set_defines
// Assertion macros for the sorted lock set, included by sorted_lock_set.sv.
// ----------------------------------------------------------------------------
`ifndef SORTED_LOCK_SET_DEFINES_SVH
`define SORTED_LOCK_SET_DEFINES_SVH

// Invariant checked at every rising clock edge outside reset.
`define SLS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle implies consequence in the next cycle.
`define SLS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/slset_pkg.sv
// ----------------------------------------------------------------------------
// slset_pkg
// Types, codes and default sizes of the sorted lock set.
// ----------------------------------------------------------------------------
package slset_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 48;

  localparam logic [1:0] MODE_INSERT     = 2'd0;
  localparam logic [1:0] MODE_LIST       = 2'd1;
  localparam logic [1:0] MODE_LIST_CLEAR = 2'd2;
  localparam logic [1:0] MODE_CLEAR      = 2'd3;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_DUPLICATE = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_LISTED    = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;
  localparam logic [2:0] STAT_CLEARED   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert_en;  // place new key at its sorted slot
    logic rotate;     // shift entries down by one, head wraps to top
  } cell_ctl_t;

endpackage

>>> design/slset_cell.sv
// ----------------------------------------------------------------------------
// slset_cell
// One slot of the sorted chain: holds a key and its access kind, compares
// against the incoming key and takes a neighbor's entry on shift.
// ----------------------------------------------------------------------------
module slset_cell #(
  parameter int KEY_BITS = slset_pkg::KEY_BITS_DEF
) (
  input  logic                  clk,
  input  slset_pkg::cell_ctl_t  ctl,
  input  logic                  valid,
  input  logic                  first,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic                  in_shared,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic                  prev_shared,
  input  logic                  prev_lt,
  input  logic [KEY_BITS-1:0]   up_key,
  input  logic                  up_shared,
  input  logic [KEY_BITS-1:0]   head_key,
  input  logic                  head_shared,
  input  logic                  wrap,
  output logic [KEY_BITS-1:0]   key,
  output logic                  shared,
  output logic                  lt,
  output logic                  eq,
  output logic                  bnd
);

  assign lt  = valid && (key < in_key);
  assign eq  = valid && (key == in_key);
  // first slot whose key is not below the new one
  assign bnd = !lt && (first || prev_lt);

  always_ff @(posedge clk) begin
    if (ctl.insert_en) begin
      if (!lt) begin
        if (bnd) begin
          key    <= in_key;
          shared <= in_shared;
        end else begin
          key    <= prev_key;
          shared <= prev_shared;
        end
      end
    end else if (ctl.rotate) begin
      if (wrap) begin
        key    <= head_key;
        shared <= head_shared;
      end else begin
        key    <= up_key;
        shared <= up_shared;
      end
    end
  end

endmodule

>>> design/sorted_lock_set.sv
// ----------------------------------------------------------------------------
// sorted_lock_set
// Sorted set of lock addresses with access kind, insert with duplicate check.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insert and clear items
// give a single result word: it shows on the cycle after the item is taken,
// with done high and last high. List items emit one word per cycle, entry
// count words (one word when the set is empty), the first on the cycle after
// the item is taken; busy stays high until the last word is produced. Listing
// rotates the cell chain down one slot a cycle and the head wraps to the top,
// so after a full listing the set is back in order. Results are not held: each
// word is valid only in the cycle done is high and must be taken then.
// ----------------------------------------------------------------------------
module sorted_lock_set #(
  parameter int DEPTH    = slset_pkg::DEPTH_DEF,
  parameter int KEY_BITS = slset_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          mode,
  input  logic [KEY_BITS-1:0] key,
  input  logic                shared_access,
  output logic                busy,
  output logic                done,
  output logic [2:0]          status,
  output logic [KEY_BITS-1:0] key_out,
  output logic                shared_out,
  output logic [3:0]          position,
  output logic                last
);

`include "sorted_lock_set_defines.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  slset_pkg::state_t    state, state_next;
  slset_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             clr, clr_next;
  logic             done_next;
  logic [2:0]       status_next;
  logic [KEY_BITS-1:0] key_out_next;
  logic             shared_out_next;
  logic [IDX_W-1:0] pos_next;
  logic             last_next;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    cell_shared, cell_lt, cell_eq, cell_bnd;

  logic             accept, any_eq, full, list_mode, list_step, list_last;
  logic [IDX_W-1:0] eq_idx, bnd_idx, emit_idx;
  logic [IDX_W+3:0] pos_ext;

  assign busy      = (state == slset_pkg::ST_LIST);
  assign accept    = start && !busy;
  assign any_eq    = |cell_eq;
  assign full      = (cnt == CNT_W'(DEPTH));
  assign list_mode = (mode == slset_pkg::MODE_LIST) || (mode == slset_pkg::MODE_LIST_CLEAR);
  assign list_step = busy || (accept && list_mode && (cnt != '0));
  assign emit_idx  = busy ? idx : '0;
  assign list_last = ((CNT_W'(emit_idx) + CNT_W'(1)) == cnt);

  assign ctl.rotate    = list_step;
  assign ctl.insert_en = accept && (mode == slset_pkg::MODE_INSERT) && !any_eq && !full;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key, up_key;
    logic                prev_shared, prev_lt, up_shared;

    if (i == 0) begin : g_first
      assign prev_key    = key;
      assign prev_shared = shared_access;
      assign prev_lt     = 1'b0;
    end else begin : g_mid
      assign prev_key    = cell_key[i-1];
      assign prev_shared = cell_shared[i-1];
      assign prev_lt     = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign up_key    = cell_key[0];
      assign up_shared = cell_shared[0];
    end else begin : g_low
      assign up_key    = cell_key[i+1];
      assign up_shared = cell_shared[i+1];
    end

    slset_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (CNT_W'(i) < cnt),
      .first       (i == 0),
      .in_key      (key),
      .in_shared   (shared_access),
      .prev_key    (prev_key),
      .prev_shared (prev_shared),
      .prev_lt     (prev_lt),
      .up_key      (up_key),
      .up_shared   (up_shared),
      .head_key    (cell_key[0]),
      .head_shared (cell_shared[0]),
      .wrap        (CNT_W'(i + 1) == cnt),
      .key         (cell_key[i]),
      .shared      (cell_shared[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i]),
      .bnd         (cell_bnd[i])
    );
  end

  // match and boundary flags each have at most one bit set; OR their indices together
  always_comb begin
    eq_idx  = '0;
    bnd_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_eq[i])  eq_idx  = eq_idx  | IDX_W'(i);
      if (cell_bnd[i]) bnd_idx = bnd_idx | IDX_W'(i);
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    idx_next        = idx;
    clr_next        = clr;
    done_next       = 1'b0;
    status_next     = slset_pkg::STAT_CLEARED;
    key_out_next    = '0;
    shared_out_next = 1'b0;
    pos_next        = '0;
    last_next       = 1'b1;

    if (list_step) begin
      done_next       = 1'b1;
      status_next     = slset_pkg::STAT_LISTED;
      key_out_next    = cell_key[0];
      shared_out_next = cell_shared[0];
      pos_next        = emit_idx;
      last_next       = list_last;
      idx_next        = emit_idx + IDX_W'(1);
      if (!busy) clr_next = (mode == slset_pkg::MODE_LIST_CLEAR);
      if (list_last) begin
        state_next = slset_pkg::ST_IDLE;
        if (busy ? clr : (mode == slset_pkg::MODE_LIST_CLEAR)) cnt_next = '0;
      end else begin
        state_next = slset_pkg::ST_LIST;
      end
    end else if (accept) begin
      done_next = 1'b1;
      unique case (mode)
        slset_pkg::MODE_INSERT: begin
          key_out_next    = key;
          shared_out_next = shared_access;
          if (any_eq) begin
            status_next = slset_pkg::STAT_DUPLICATE;
            pos_next    = eq_idx;
          end else if (full) begin
            status_next = slset_pkg::STAT_FULL;
          end else begin
            status_next = slset_pkg::STAT_INSERTED;
            pos_next    = bnd_idx;
            cnt_next    = cnt + CNT_W'(1);
          end
        end
        slset_pkg::MODE_LIST, slset_pkg::MODE_LIST_CLEAR: begin
          // only reached with an empty set
          status_next = slset_pkg::STAT_EMPTY;
        end
        slset_pkg::MODE_CLEAR: begin
          status_next = slset_pkg::STAT_CLEARED;
          cnt_next    = '0;
        end
        default: begin
          status_next = slset_pkg::STAT_CLEARED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slset_pkg::ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
      clr   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
      clr   <= clr_next;
      done  <= done_next;
    end
  end

  assign pos_ext = {4'b0000, pos_next};

  always_ff @(posedge clk) begin
    status     <= status_next;
    key_out    <= key_out_next;
    shared_out <= shared_out_next;
    position   <= pos_ext[3:0];
    last       <= last_next;
  end

  `SLS_CHECK(a_cnt_bound, cnt <= CNT_W'(DEPTH), "entry count above depth")
  `SLS_CHECK(a_eq_onehot, $onehot0(cell_eq), "key matches more than one entry")
  `SLS_NEXT(a_single_result, accept && !list_step, done && last && !busy, "single-word item did not finish")
  `SLS_NEXT(a_list_emits, busy, done && (status == slset_pkg::STAT_LISTED), "listing skipped a cycle")
  `SLS_NEXT(a_list_ends, list_step && list_last, !busy && last, "listing did not end on last entry")

endmodule
